// ===== src/keyed_group_bump_allocator_defines.svh =====
`ifndef KEYED_GROUP_BUMP_ALLOCATOR_DEFINES_SVH
`define KEYED_GROUP_BUMP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define KGBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define KGBA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// what must hold on the cycle after reset is applied
`define KGBA_ASSERT_RST(lbl, clk, rstn, cons, msg) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kgba_pkg.sv =====
`timescale 1ns / 1ps

package kgba_pkg;

    localparam int DEF_MAX_GROUPS  = 16;
    localparam int DEF_MAX_ENTRIES = 1024;

    localparam int KEY_W    = 64;
    localparam int DATA_W   = 32;
    localparam int STRIDE_W = 12;
    localparam int STAT_W   = 2;
    localparam int ENTRY_W  = 10;
    localparam int GROUP_W  = 4;
    localparam int STEP_W   = 3;

    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT      = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL        = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZERO_STRIDE = 2'd3;

    localparam logic [STEP_W-1:0] STEP_WIDE   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_NARROW = 3'd2;

    typedef struct packed {
        logic [KEY_W-1:0]    format_key;
        logic                mesh_usable;
        logic                wide_indices;
        logic [DATA_W-1:0]   vertex_bytes;
        logic [DATA_W-1:0]   index_bytes;
        logic [STRIDE_W-1:0] vertex_stride;
    } req_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ENTRY_W-1:0] entry_number;
        logic [GROUP_W-1:0] group_number;
        logic               new_group;
        logic [DATA_W-1:0]  vertex_offset;
        logic [DATA_W-1:0]  index_offset;
        logic [DATA_W-1:0]  vertex_count;
        logic [STEP_W-1:0]  index_step;
    } rsp_word_t;

    typedef struct packed {
        logic              load;
        logic              div_start;
        logic              clr_search;
        logic              rd_issue;
        logic              step_search;
        logic              take_hit;
        logic              take_miss;
        logic              set_err;
        logic [STAT_W-1:0] err_code;
        logic              finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] pre_err;
        logic              at_end;
        logic              key_hit;
        logic              groups_full;
        logic              div_done;
        logic              out_free;
    } dp_status_t;

endpackage

// ===== src/kgba_ctrl.sv =====
`timescale 1ns / 1ps

module kgba_ctrl
    import kgba_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.pre_err != ST_OK) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = sts.pre_err;
                    state_next   = S_DONE;
                end else begin
                    cmd.clr_search = 1'b1;
                    cmd.div_start  = 1'b1;
                    state_next     = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (sts.at_end) begin
                    if (sts.groups_full) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_FULL;
                        state_next   = S_DONE;
                    end else begin
                        cmd.take_miss = 1'b1;
                        state_next    = S_WAIT;
                    end
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_CMP;
                end
            end
            S_CMP: begin
                if (sts.key_hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_WAIT;
                end else begin
                    cmd.step_search = 1'b1;
                    state_next      = S_SEARCH;
                end
            end
            S_WAIT: begin
                if (sts.div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/kgba_datapath.sv =====
`timescale 1ns / 1ps

module kgba_datapath
    import kgba_pkg::*;
#(
    parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  req_word_t  s_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t sts,
    output logic       m_valid,
    input  logic       m_ready,
    output rsp_word_t  m_data
);

    localparam int GW        = $clog2(MAX_GROUPS);
    localparam int GCW       = $clog2(MAX_GROUPS + 1);
    localparam int ECW       = $clog2(MAX_ENTRIES + 1);
    localparam int DIV_STEPS = DATA_W;
    localparam int DCW       = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              wide;
        logic [DATA_W-1:0] vtot;
        logic [DATA_W-1:0] itot;
    } grp_entry_t;

    grp_entry_t grp_mem [MAX_GROUPS];
    grp_entry_t rd_data_reg;

    req_word_t         req_reg;
    logic [STAT_W-1:0] stat_reg;
    logic [ECW-1:0]    entries_used_reg;
    logic [GCW-1:0]    groups_used_reg;
    logic [GCW-1:0]    g_reg;
    logic [GW-1:0]     found_reg;
    logic              opened_reg;
    logic              wide_cur_reg;
    logic [DATA_W-1:0] vtot_reg;
    logic [DATA_W-1:0] itot_reg;

    logic [STRIDE_W-1:0] rem_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [DCW-1:0]      div_cnt_reg;
    logic [STRIDE_W:0]   div_trial;

    logic      m_valid_reg;
    rsp_word_t m_data_reg;
    rsp_word_t rsp_next;
    logic      commit;

    assign commit = cmd.finish && (stat_reg == ST_OK);

    // group table: one read port (search), one write port (commit)
    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_data_reg <= grp_mem[g_reg[GW-1:0]];
        end
        if (commit) begin
            grp_mem[found_reg] <= '{key:  req_reg.format_key,
                                    wide: wide_cur_reg,
                                    vtot: vtot_reg + req_reg.vertex_bytes,
                                    itot: itot_reg + req_reg.index_bytes};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_data;
            stat_reg <= ST_OK;
        end else if (cmd.set_err) begin
            stat_reg <= cmd.err_code;
        end
        if (cmd.clr_search) begin
            g_reg <= '0;
        end else if (cmd.step_search) begin
            g_reg <= g_reg + 1'b1;
        end
        if (cmd.take_hit) begin
            found_reg    <= g_reg[GW-1:0];
            opened_reg   <= 1'b0;
            wide_cur_reg <= rd_data_reg.wide;
            vtot_reg     <= rd_data_reg.vtot;
            itot_reg     <= rd_data_reg.itot;
        end else if (cmd.take_miss) begin
            found_reg    <= groups_used_reg[GW-1:0];
            opened_reg   <= 1'b1;
            wide_cur_reg <= req_reg.wide_indices;
            vtot_reg     <= '0;
            itot_reg     <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_used_reg <= '0;
            groups_used_reg  <= '0;
        end else if (commit) begin
            entries_used_reg <= entries_used_reg + 1'b1;
            if (opened_reg) begin
                groups_used_reg <= groups_used_reg + 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, req_reg.vertex_stride};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= DCW'(DIV_STEPS);
        end else if (div_cnt_reg != '0) begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= req_reg.vertex_bytes;
        end else if (div_cnt_reg != '0) begin
            if (!div_trial[STRIDE_W]) begin
                rem_reg <= div_trial[STRIDE_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[STRIDE_W-2:0], quo_reg[DATA_W-1]};
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        priority if (!req_reg.mesh_usable) begin
            sts.pre_err = ST_REJECT;
        end else if (req_reg.vertex_stride == '0) begin
            sts.pre_err = ST_ZERO_STRIDE;
        end else if (entries_used_reg == ECW'(MAX_ENTRIES)) begin
            sts.pre_err = ST_FULL;
        end else begin
            sts.pre_err = ST_OK;
        end
        sts.at_end      = (g_reg == groups_used_reg);
        sts.key_hit     = (rd_data_reg.key == req_reg.format_key);
        sts.groups_full = (groups_used_reg == GCW'(MAX_GROUPS));
        sts.div_done    = (div_cnt_reg == '0);
        sts.out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        rsp_next        = '0;
        rsp_next.status = stat_reg;
        if (stat_reg == ST_OK) begin
            rsp_next.entry_number  = ENTRY_W'(entries_used_reg);
            rsp_next.group_number  = GROUP_W'(found_reg);
            rsp_next.new_group     = opened_reg;
            rsp_next.vertex_offset = vtot_reg;
            rsp_next.index_offset  = itot_reg;
            rsp_next.vertex_count  = quo_reg;
            rsp_next.index_step    = wide_cur_reg ? STEP_WIDE : STEP_NARROW;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/keyed_group_bump_allocator.sv =====
`timescale 1ns / 1ps

// Keyed group bump allocator.
// s_ channel: one request word (format key, usable flag, index width, sizes,
// vertex stride). m_ channel: one result word per request (status, entry and
// group numbers, new-group flag, vertex/index byte offsets, vertex count,
// index step). Both channels are valid/ready.
// One request is in work at a time. After acceptance the open groups are
// scanned in turn, each with a table read and then a key compare, while a
// bit-serial divider forms the vertex count. An error caught on the request
// itself returns without the search or the divider. A new request is not
// taken until the last one has finished.
// The result sits in an output register; the next request is taken while it
// waits. If m_ready stays low, a finished second result holds inside the
// block until the output register frees, and s_ready stays low meanwhile.
// Reset (aresetn low, synchronous) empties the group and entry counts; the
// group table is not cleared, since only opened groups are ever read.
module keyed_group_bump_allocator
    import kgba_pkg::*;
#(
    parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  req_word_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rsp_word_t m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    kgba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    kgba_datapath #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== src/kgba_checker.sv =====
`timescale 1ns / 1ps
`include "keyed_group_bump_allocator_defines.svh"

module kgba_checker
    import kgba_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input rsp_word_t m_data
);

    logic out_stall;
    logic s_take;
    logic rsp_err;
    logic rsp_ok;
    logic rsp_clean;
    logic step_ok;

    assign out_stall = m_valid && !m_ready;
    assign s_take    = s_valid && s_ready;
    assign rsp_err   = m_valid && (m_data.status != ST_OK);
    assign rsp_ok    = m_valid && (m_data.status == ST_OK);
    assign rsp_clean = (m_data.entry_number == '0) && (m_data.group_number == '0) &&
                       !m_data.new_group && (m_data.vertex_offset == '0) &&
                       (m_data.index_offset == '0) && (m_data.vertex_count == '0) &&
                       (m_data.index_step == '0);
    assign step_ok   = (m_data.index_step == STEP_WIDE) || (m_data.index_step == STEP_NARROW);

    `KGBA_ASSERT_NXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data), "word not held")
    `KGBA_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_take, !s_ready, "second word taken")
    `KGBA_ASSERT_IMP(a_err_zero, aclk, aresetn, rsp_err, rsp_clean, "error word not clean")
    `KGBA_ASSERT_IMP(a_ok_step, aclk, aresetn, rsp_ok, step_ok, "bad index step")
    `KGBA_ASSERT_RST(a_rst_idle, aclk, aresetn, !m_valid, "result valid after reset")

endmodule

bind keyed_group_bump_allocator kgba_checker u_kgba_checker (.*);
